// ===== rtl/nnds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnds_pkg
// Shared types and constants of the nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package nnds_pkg;

  // Fixed widths of the configuration registers.
  localparam int unsigned CFG_DIM_W  = 13;
  localparam int unsigned CFG_STEP_W = 21;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned CFG_IDX_W  = 3;

  // Default geometry of the fixed-point datapath.
  localparam int unsigned DIM_BITS_DEF  = 12;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA  = 3'd6;

  // Register reset values.
  localparam logic [CFG_DIM_W-1:0]  RST_SRC_WIDTH  = 13'd640;
  localparam logic [CFG_DIM_W-1:0]  RST_SRC_HEIGHT = 13'd480;
  localparam logic [CFG_DIM_W-1:0]  RST_DST_WIDTH  = 13'd640;
  localparam logic [CFG_DIM_W-1:0]  RST_DST_HEIGHT = 13'd480;
  localparam logic [CFG_STEP_W-1:0] RST_STEP_X     = 21'd65536;
  localparam logic [CFG_STEP_W-1:0] RST_STEP_Y     = 21'd65536;
  localparam logic                  RST_HAS_ALPHA  = 1'b1;

  // Alpha value given to three-byte sources.
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [CFG_DIM_W-1:0]  src_width;
    logic [CFG_DIM_W-1:0]  src_height;
    logic [CFG_DIM_W-1:0]  dst_width;
    logic [CFG_DIM_W-1:0]  dst_height;
    logic [CFG_STEP_W-1:0] step_x;
    logic [CFG_STEP_W-1:0] step_y;
    logic                  has_alpha;
  } cfg_t;

  // Decision for the source pixel presented to the selector.
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } sel_t;

endpackage

// ===== rtl/nnds_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnds_select
// Raster position counters and fixed-point accumulators that decide which
// source pixels are kept.
// ----------------------------------------------------------------------------
module nnds_select #(
  parameter int unsigned DIM_BITS  = nnds_pkg::DIM_BITS_DEF,
  parameter int unsigned FRAC_BITS = nnds_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nnds_pkg::cfg_t  cfg_i,
  input  logic            adv_i,
  output nnds_pkg::sel_t  sel_o
);
  import nnds_pkg::*;

  localparam int unsigned PW = DIM_BITS + 1 + FRAC_BITS;
  localparam int unsigned EW = (CFG_DIM_W > DIM_BITS + 1) ? CFG_DIM_W : DIM_BITS + 1;
  localparam int unsigned SW = (CFG_STEP_W > FRAC_BITS + 1) ? CFG_STEP_W : FRAC_BITS + 1;
  localparam int unsigned AW = ((PW > SW) ? PW : SW) + 1;

  localparam logic [EW-1:0] DIM_MAX  = EW'(1) << DIM_BITS;
  localparam logic [SW-1:0] STEP_ONE = SW'(1) << FRAC_BITS;

  logic [DIM_BITS-1:0] src_col_q, src_col_d;
  logic [DIM_BITS-1:0] src_row_q, src_row_d;
  logic [DIM_BITS:0]   dst_col_q, dst_col_d;
  logic [DIM_BITS:0]   dst_row_q, dst_row_d;
  logic [PW-1:0]       x_pos_q, x_pos_d;
  logic [PW-1:0]       y_pos_q, y_pos_d;

  logic [DIM_BITS:0] sw, sh, dw, dh;
  logic [SW-1:0]     sx, sy;
  logic [PW-1:0]     x_next, y_next;
  logic              last_col, last_row, row_active, col_hit;

  // Size registers of zero act as one, sizes above the counter range clamp.
  function automatic logic [DIM_BITS:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [EW-1:0] ve;
    logic [EW-1:0] r;
    ve = EW'(v);
    if (ve == '0) begin
      r = EW'(1);
    end else if (ve > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = ve;
    end
    return r[DIM_BITS:0];
  endfunction

  // Steps below one source pixel act as exactly one.
  function automatic logic [SW-1:0] eff_step(input logic [CFG_STEP_W-1:0] v);
    logic [SW-1:0] ve;
    ve = SW'(v);
    return (ve < STEP_ONE) ? STEP_ONE : ve;
  endfunction

  function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] pos,
                                            input logic [SW-1:0] step);
    logic [AW-1:0] s;
    s = AW'(pos) + AW'(step);
    return (s[AW-1:PW] != '0) ? {PW{1'b1}} : s[PW-1:0];
  endfunction

  always_comb begin
    sw = eff_dim(cfg_i.src_width);
    sh = eff_dim(cfg_i.src_height);
    dw = eff_dim(cfg_i.dst_width);
    dh = eff_dim(cfg_i.dst_height);
    sx = eff_step(cfg_i.step_x);
    sy = eff_step(cfg_i.step_y);

    last_col   = {1'b0, src_col_q} >= (sw - 1'b1);
    last_row   = {1'b0, src_row_q} >= (sh - 1'b1);
    row_active = (dst_row_q < dh) &&
                 (({1'b0, src_row_q} == y_pos_q[PW-1:FRAC_BITS]) || last_row);
    col_hit    = ({1'b0, src_col_q} == x_pos_q[PW-1:FRAC_BITS]) || last_col;

    sel_o.emit      = row_active && (dst_col_q < dw) && col_hit;
    sel_o.row_end   = (dst_col_q >= (dw - 1'b1)) || last_col;
    sel_o.frame_end = sel_o.row_end && ((dst_row_q >= (dh - 1'b1)) || last_row);

    x_next = sat_add(x_pos_q, sx);
    y_next = sat_add(y_pos_q, sy);
  end

  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    dst_col_d = dst_col_q;
    dst_row_d = dst_row_q;
    x_pos_d   = x_pos_q;
    y_pos_d   = y_pos_q;
    if (adv_i) begin
      if (sel_o.emit) begin
        dst_col_d = dst_col_q + 1'b1;
        x_pos_d   = x_next;
      end
      if (last_col) begin
        if (row_active) begin
          dst_row_d = dst_row_q + 1'b1;
          y_pos_d   = y_next;
        end
        dst_col_d = '0;
        x_pos_d   = '0;
        src_col_d = '0;
        if (last_row) begin
          src_row_d = '0;
          dst_row_d = '0;
          y_pos_d   = '0;
        end else begin
          src_row_d = src_row_q + 1'b1;
        end
      end else begin
        src_col_d = src_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      x_pos_q   <= '0;
      y_pos_q   <= '0;
    end else begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      dst_col_q <= dst_col_d;
      dst_row_q <= dst_row_d;
      x_pos_q   <= x_pos_d;
      y_pos_q   <= y_pos_d;
    end
  end

`ifndef SYNTHESIS
  // The last source pixel of a frame returns every counter to the origin.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && last_col && last_row) |=> (src_col_q == '0 && src_row_q == '0 &&
                                         dst_row_q == '0 && y_pos_q == '0))
    else $error("frame wrap did not clear the position state");

  // Within a row the horizontal accumulator never moves backward.
  a_x_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && !last_col) |=> (x_pos_q >= $past(x_pos_q)))
    else $error("horizontal position decreased inside a row");

  // A kept pixel always advances the destination column by one.
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && sel_o.emit && !last_col) |=> (dst_col_q == $past(dst_col_q) + 1'b1))
    else $error("destination column did not advance on a kept pixel");
`endif

endmodule

// ===== rtl/nearest_neighbor_downscaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler
// Nearest-neighbor decimation of a BGR(A) raster stream into RGBA pixels.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock while its input is not stalled,
// in raster order, top row first, and keeps the pixels that nearest-neighbor
// selection picks for the destination grid; every kept pixel appears in the
// next cycle on the output register as red, green, blue and alpha, with
// row_end and frame_end marks, while the other source pixels produce no
// output transaction. The sustained rate is one source pixel per clock while
// nothing stalls, and a kept pixel passes through the single output register
// that stands after the selection logic. The input is stalled only while that
// register holds a result whose output transaction is itself stalled. Source
// column x and row y are tracked by counters, and the destination grid by
// 13.16 fixed-point accumulators that advance by step_x and step_y and saturate
// at their all-ones value. Configuration registers are written through a
// separate port that is always ready; they take effect immediately and do not
// reset the raster counters, so they should be written between frames. There
// is no memory and no clearing pass after reset.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler #(
  parameter int unsigned DIM_BITS  = nnds_pkg::DIM_BITS_DEF,
  parameter int unsigned FRAC_BITS = nnds_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nnds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nnds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Source pixel channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_blue_i,
  input  logic [7:0]                      in_green_i,
  input  logic [7:0]                      in_red_i,
  input  logic [7:0]                      in_alpha_i,
  // Destination pixel channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_blue_o,
  output logic [7:0]                      out_alpha_o,
  output logic                            row_end_o,
  output logic                            frame_end_o
);
  import nnds_pkg::*;

  cfg_t cfg_q;
  sel_t sel;
  logic in_accept;
  logic out_load;

  logic       out_valid_q, out_valid_d;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic       row_end_q, frame_end_q;

  // The configuration port never back-pressures.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= RST_SRC_WIDTH;
      cfg_q.src_height <= RST_SRC_HEIGHT;
      cfg_q.dst_width  <= RST_DST_WIDTH;
      cfg_q.dst_height <= RST_DST_HEIGHT;
      cfg_q.step_x     <= RST_STEP_X;
      cfg_q.step_y     <= RST_STEP_Y;
      cfg_q.has_alpha  <= RST_HAS_ALPHA;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data_i[CFG_DIM_W-1:0];
        REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data_i[CFG_DIM_W-1:0];
        REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data_i[CFG_DIM_W-1:0];
        REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data_i[CFG_DIM_W-1:0];
        REG_STEP_X:     cfg_q.step_x     <= cfg_data_i[CFG_STEP_W-1:0];
        REG_STEP_Y:     cfg_q.step_y     <= cfg_data_i[CFG_STEP_W-1:0];
        REG_HAS_ALPHA:  cfg_q.has_alpha  <= cfg_data_i[0];
        default: begin
          // Writes to unmapped indexes are dropped.
        end
      endcase
    end
  end

  // A new source pixel is taken unless a result is waiting on a stalled output.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  nnds_select #(
    .DIM_BITS  (DIM_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .adv_i  (in_accept),
    .sel_o  (sel)
  );

  // A kept pixel loads the output register; accepting a pixel that is dropped
  // while the register is free simply empties it.
  assign out_load = in_accept && sel.emit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (!in_stall_o) begin
      out_valid_d = out_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; they only change on a load.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q       <= in_red_i;
      green_q     <= in_green_i;
      blue_q      <= in_blue_i;
      alpha_q     <= cfg_q.has_alpha ? in_alpha_i : ALPHA_OPAQUE;
      row_end_q   <= sel.row_end;
      frame_end_q <= sel.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_alpha_o = alpha_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

`ifndef SYNTHESIS
  // Input back-pressure only ever comes from a held result.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // The frame mark is only given on the last pixel of a row.
  a_frame_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |-> row_end_o)
    else $error("frame_end without row_end");

  // A kept pixel is always presented on the next cycle.
  a_kept_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("kept pixel did not reach the output register");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
// Source pixels go through a queue into a clocked driver. A clocked monitor
// takes the destination pixels. Every source pixel that the block accepts is
// run through a predictor of the selection logic, which has its own copy of
// the registers, the raster counters and the fixed-point accumulators. Each
// pixel it keeps goes into a queue of expected RGBA pixels, and the monitor
// compares every output transaction with the oldest entry. The run starts
// with short directed frames for the clamping and edge cases. Random
// geometries follow, mostly well-formed scaling ratios with some noise, under
// three idling patterns and one long output hold-off. The run closes with two
// short runs at the largest width and height.
// ----------------------------------------------------------------------------
module testbench;
  import nnds_pkg::*;

  localparam int unsigned FRAC      = FRAC_BITS_DEF;
  localparam int unsigned POS_W     = DIM_BITS_DEF + 1 + FRAC;
  localparam longint unsigned DIM_LIMIT = 64'd1 << DIM_BITS_DEF;
  localparam longint unsigned STEP_ONE  = 64'd1 << FRAC;
  localparam longint unsigned POS_MAX   = (64'd1 << POS_W) - 64'd1;

  // Index 7 has no register behind it. A write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned STUCK_LIMIT  = 1000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned RANDOM_ITEMS = 1450;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } bgra_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       frame_end;
  } rgba_t;

  // Every input of the block has a known value from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            in_blue_i   = '0;
  logic [7:0]            in_green_i  = '0;
  logic [7:0]            in_red_i    = '0;
  logic [7:0]            in_alpha_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            out_red_o;
  logic [7:0]            out_green_o;
  logic [7:0]            out_blue_o;
  logic [7:0]            out_alpha_o;
  logic                  row_end_o;
  logic                  frame_end_o;

  nearest_neighbor_downscaler i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Source pixels still to be offered, and destination pixels still owed.
  bgra_t source_pixels[$];
  rgba_t expected_pixels[$];

  int unsigned fail_count    = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;
  int unsigned stuck_cycles  = 0;

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the block: register copy, source position,
  // destination position and the two fixed-point accumulators.
  // --------------------------------------------------------------------------
  cfg_t                    shadow_cfg;
  logic [DIM_BITS_DEF-1:0] src_col = '0;
  logic [DIM_BITS_DEF-1:0] src_row = '0;
  logic [DIM_BITS_DEF:0]   dst_col = '0;
  logic [DIM_BITS_DEF:0]   dst_row = '0;
  logic [POS_W-1:0]        x_pos   = '0;
  logic [POS_W-1:0]        y_pos   = '0;

  function automatic cfg_t make_cfg(input logic [CFG_DIM_W-1:0] sw, sh, dw, dh,
                                    input logic [CFG_STEP_W-1:0] sx, sy,
                                    input logic alpha);
    cfg_t c;
    c.src_width  = sw;
    c.src_height = sh;
    c.dst_width  = dw;
    c.dst_height = dh;
    c.step_x     = sx;
    c.step_y     = sy;
    c.has_alpha  = alpha;
    return c;
  endfunction

  // A size of zero behaves as one. Sizes above the counter range are clipped.
  function automatic longint unsigned clamp_dim(input logic [CFG_DIM_W-1:0] v);
    if (v == '0) return 64'd1;
    if (64'(v) > DIM_LIMIT) return DIM_LIMIT;
    return 64'(v);
  endfunction

  // Steps below 1.0, zero included, behave as exactly 1.0.
  function automatic longint unsigned clamp_step(input logic [CFG_STEP_W-1:0] v);
    return (64'(v) < STEP_ONE) ? STEP_ONE : 64'(v);
  endfunction

  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p,
                                               input longint unsigned s);
    longint unsigned sum;
    sum = 64'(p) + s;
    return (sum > POS_MAX) ? '1 : POS_W'(sum);
  endfunction

  // Decides whether this source pixel lands on the destination grid. A pixel
  // that is kept is queued as RGBA. Then the raster counters move on.
  task automatic scale_pixel(input bgra_t px);
    longint unsigned sw, sh, dw, dh, sx, sy;
    logic  last_col, last_row, row_hit;
    rgba_t kept;
    sw = clamp_dim(shadow_cfg.src_width);
    sh = clamp_dim(shadow_cfg.src_height);
    dw = clamp_dim(shadow_cfg.dst_width);
    dh = clamp_dim(shadow_cfg.dst_height);
    sx = clamp_step(shadow_cfg.step_x);
    sy = clamp_step(shadow_cfg.step_y);
    // A column or row at or past the end counts as the last one. This
    // matters after a register write in the middle of a frame.
    last_col = 64'(src_col) >= sw - 64'd1;
    last_row = 64'(src_row) >= sh - 64'd1;
    row_hit  = (64'(dst_row) < dh) &&
               ((64'(src_row) == (64'(y_pos) >> FRAC)) || last_row);

    if (row_hit && 64'(dst_col) < dw &&
        ((64'(src_col) == (64'(x_pos) >> FRAC)) || last_col)) begin
      kept.red       = px.red;
      kept.green     = px.green;
      kept.blue      = px.blue;
      kept.alpha     = shadow_cfg.has_alpha ? px.alpha : ALPHA_OPAQUE;
      kept.row_end   = (64'(dst_col) + 64'd1 >= dw) || last_col;
      kept.frame_end = kept.row_end && ((64'(dst_row) + 64'd1 >= dh) || last_row);
      expected_pixels.push_back(kept);
      dst_col = dst_col + 1'b1;
      x_pos   = advance(x_pos, sx);
    end

    if (last_col) begin
      if (row_hit) begin
        dst_row = dst_row + 1'b1;
        y_pos   = advance(y_pos, sy);
      end
      dst_col = '0;
      x_pos   = '0;
      src_col = '0;
      if (last_row) begin
        src_row = '0;
        dst_row = '0;
        y_pos   = '0;
      end else begin
        src_row = src_row + 1'b1;
      end
    end else begin
      src_col = src_col + 1'b1;
    end
  endtask

  task automatic report_failure(input string what, input rgba_t want, input rgba_t seen);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected r=%02h g=%02h b=%02h a=%02h row_end=%0b frame_end=%0b",
               $realtime, what, want.red, want.green, want.blue, want.alpha,
               want.row_end, want.frame_end);
      $display("%0t %s: actual   r=%02h g=%02h b=%02h a=%02h row_end=%0b frame_end=%0b",
               $realtime, what, seen.red, seen.green, seen.blue, seen.alpha,
               seen.row_end, seen.frame_end);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver. A new pixel is loaded only when the channel is empty or its
  // current transaction completes at this edge, so a stalled pixel holds.
  // Each accepted pixel goes to the predictor at the edge where it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : tx_drive
    bgra_t next_px;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        scale_pixel({in_blue_i, in_green_i, in_red_i, in_alpha_i});
      end
      if (!in_valid_i || !in_stall_o) begin
        if (source_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_px = source_pixels.pop_front();
          in_valid_i <= 1'b1;
          in_blue_i  <= next_px.blue;
          in_green_i <= next_px.green;
          in_red_i   <= next_px.red;
          in_alpha_i <= next_px.alpha;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. It checks each output transaction against the oldest expected
  // pixel. It also drives the stall, either at random or as one long
  // hold-off. A hold-off starts on a pending hold request, once the block
  // offers a pixel.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : rx_check
    rgba_t seen, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.red       = out_red_o;
        seen.green     = out_green_o;
        seen.blue      = out_blue_o;
        seen.alpha     = out_alpha_o;
        seen.row_end   = row_end_o;
        seen.frame_end = frame_end_o;
        if (expected_pixels.size() == 0) begin
          report_failure("unexpected pixel", '0, seen);
        end else begin
          want = expected_pixels.pop_front();
          if (seen.red !== want.red || seen.green !== want.green ||
              seen.blue !== want.blue || seen.alpha !== want.alpha ||
              seen.row_end !== want.row_end || seen.frame_end !== want.frame_end) begin
            report_failure("pixel mismatch", want, seen);
          end
        end
      end

      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (holds_done < hold_requests && out_valid_o) begin
        hold_left   <= HOLD_CYCLES;
        holds_done  <= holds_done + 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // The watchdog counts cycles in which no channel completes a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles", $realtime, STUCK_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and sequencing.
  // --------------------------------------------------------------------------

  // Waits until every queued pixel is taken and every expected pixel has
  // come out. It then keeps waiting so that source pixels that make no output
  // are through too. The caller stands just after a rising edge on return.
  task automatic wait_drained();
    while (source_pixels.size() != 0 || in_valid_i || expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register. Bits above the register width carry random junk,
  // which the block must drop. Valid stays high for a following write. The
  // caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] junk;
    int unsigned field_w;
    case (idx)
      REG_STEP_X, REG_STEP_Y: field_w = CFG_STEP_W;
      REG_HAS_ALPHA:          field_w = 1;
      default:                field_w = CFG_DIM_W;
    endcase
    junk = CFG_DATA_W'($urandom);
    if (field_w < CFG_DATA_W) begin
      value = value | ((junk >> field_w) << field_w);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SRC_WIDTH:  shadow_cfg.src_width  = value[CFG_DIM_W-1:0];
      REG_SRC_HEIGHT: shadow_cfg.src_height = value[CFG_DIM_W-1:0];
      REG_DST_WIDTH:  shadow_cfg.dst_width  = value[CFG_DIM_W-1:0];
      REG_DST_HEIGHT: shadow_cfg.dst_height = value[CFG_DIM_W-1:0];
      REG_STEP_X:     shadow_cfg.step_x     = value[CFG_STEP_W-1:0];
      REG_STEP_Y:     shadow_cfg.step_y     = value[CFG_STEP_W-1:0];
      REG_HAS_ALPHA:  shadow_cfg.has_alpha  = value[0];
      default: ;
    endcase
  endtask

  // Runs one phase. The phase waits until the block is idle, loads the
  // geometry and queues the pixels. The raster counters are not reset, so a
  // phase that stops in the middle of a frame leaves the next geometry to
  // pick up from there. Directed phases mix all-zero and all-one pixels
  // with random ones.
  task automatic run_phase(input cfg_t c, input int unsigned count,
                           input int unsigned src_pct, input int unsigned rcv_pct,
                           input bit directed);
    bgra_t px;
    wait_drained();
    write_reg(REG_SRC_WIDTH,  CFG_DATA_W'(c.src_width));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(c.src_height));
    write_reg(REG_DST_WIDTH,  CFG_DATA_W'(c.dst_width));
    write_reg(REG_DST_HEIGHT, CFG_DATA_W'(c.dst_height));
    write_reg(REG_STEP_X,     CFG_DATA_W'(c.step_x));
    write_reg(REG_STEP_Y,     CFG_DATA_W'(c.step_y));
    write_reg(REG_HAS_ALPHA,  CFG_DATA_W'(c.has_alpha));
    cfg_valid_i  <= 1'b0;
    src_idle_pct <= src_pct;
    rcv_idle_pct <= rcv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      px = $urandom;
      if (directed && i % 3 == 0) px = '0;
      if (directed && i % 3 == 1) px = '1;
      source_pixels.push_back(px);
    end
  endtask

  // Most geometries are well-formed downscales whose step is about
  // src/dst, sometimes nudged up so that the last column or row cuts a
  // destination row or frame short. The rest are noise: any size (zero and
  // oversize included), any step, and destinations larger than the source.
  task automatic pick_config(output cfg_t c, output int unsigned count);
    int unsigned sw, sh, dw, dh, sx, sy;
    if ($urandom_range(99) < 80) begin
      sw = $urandom_range(1, 16);
      sh = $urandom_range(1, 8);
      dw = $urandom_range(1, sw);
      dh = $urandom_range(1, sh);
      sx = (sw << FRAC) / dw;
      sy = (sh << FRAC) / dh;
      if ($urandom_range(3) == 0) sx = sx + $urandom_range(0, 'h7FF);
      if ($urandom_range(3) == 0) sy = sy + $urandom_range(0, 'h7FF);
      count = sw * sh * $urandom_range(1, 3) + $urandom_range(0, sw);
    end else begin
      sw = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 20);
      sh = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 20);
      dw = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 20);
      dh = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 20);
      sx = $urandom_range(0, (1 << CFG_STEP_W) - 1);
      sy = $urandom_range(0, (1 << CFG_STEP_W) - 1);
      count = $urandom_range(20, 150);
    end
    c = make_cfg(CFG_DIM_W'(sw), CFG_DIM_W'(sh), CFG_DIM_W'(dw), CFG_DIM_W'(dh),
                 CFG_STEP_W'(sx), CFG_STEP_W'(sy), 1'($urandom_range(1)));
  endtask

  initial begin
    cfg_t        c;
    int unsigned count;
    int unsigned random_total;
    random_total = 0;
    shadow_cfg = make_cfg(RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_DST_WIDTH, RST_DST_HEIGHT,
                          RST_STEP_X, RST_STEP_Y, RST_HAS_ALPHA);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A write to the unused index must leave every register alone.
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;

    // Identity 3x2 frame. Every pixel is kept, and the row and frame ends
    // fall on the last column and the last pixel.
    run_phase(make_cfg(13'd3, 13'd2, 13'd3, 13'd2, 21'h10000, 21'h10000, 1'b1),
              6, 15, 81, 1'b1);
    // Zero sizes act as one, and steps below one act as one. Every pixel is
    // a one-pixel frame, and the source alpha is replaced by opaque.
    run_phase(make_cfg(13'd0, 13'd0, 13'd0, 13'd0, 21'h00000, 21'h0FFFF, 1'b0),
              3, 15, 81, 1'b1);
    // The destination is wider and taller than the source can fill. The
    // last source column closes each row, and the last source row closes
    // the frame.
    run_phase(make_cfg(13'd3, 13'd2, 13'd5, 13'd4, 21'h20000, 21'h18000, 1'b1),
              6, 15, 81, 1'b1);
    // The destination is complete early. The rest of the row and the whole
    // second row give no output.
    run_phase(make_cfg(13'd4, 13'd2, 13'd2, 13'd1, 21'h10000, 21'h10000, 1'b0),
              8, 15, 81, 1'b1);

    // Every source pixel is kept here, so a long output hold-off backs the
    // block up until it stalls its input while the driver keeps offering.
    run_phase(make_cfg(13'd8, 13'd8, 13'd8, 13'd8, 21'h10000, 21'h10000, 1'b1),
              200, 15, 81, 1'b0);
    hold_requests <= hold_requests + 1;
    random_total = 200;

    // Random geometries. The first third uses a slow receiver, the second
    // third a slow sender, and the last third runs with no idling.
    while (random_total < RANDOM_ITEMS) begin
      pick_config(c, count);
      if (count > 200) count = 200;
      if (random_total < RANDOM_ITEMS / 3) begin
        run_phase(c, count, 15, 81, 1'b0);
      end else if (random_total < 2 * RANDOM_ITEMS / 3) begin
        run_phase(c, count, 81, 15, 1'b0);
      end else begin
        run_phase(c, count, 0, 0, 1'b0);
      end
      random_total += count;
    end

    // Largest geometries. The first is a full-width row with oversize
    // values that clip and maximal steps. The second is one column at full
    // height with every row kept.
    run_phase(make_cfg(13'h1FFF, 13'd1, 13'h1FFF, 13'd1, 21'h1FFFFF, 21'h1FFFFF, 1'b1),
              100, 0, 0, 1'b0);
    run_phase(make_cfg(13'd1, 13'h1FFF, 13'd1, 13'd4096, 21'h10000, 21'h10000, 1'b0),
              100, 0, 0, 1'b0);

    wait_drained();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nnds_pkg.sv
rtl/nnds_select.sv
rtl/nearest_neighbor_downscaler.sv
dv/testbench.sv
